FILE: sv/xsf_pkg.sv
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants of the sprite framebuffer
// Operation codes, fixed field widths and the command word that passes
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package xsf_pkg;

  localparam int ROW_PIXELS = 8;
  localparam int LINE_W_MAX = 6;  // holds any line of a frame up to 64 lines
  localparam int COL_W_MAX  = 7;  // holds any column of a frame up to 128 columns

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [LINE_W_MAX-1:0] line;
    logic [COL_W_MAX-1:0]  col;
    logic [ROW_PIXELS-1:0] bits;
    logic                  last;
  } cmd_t;

endpackage

FILE: sv/xsf_ifs.sv
// ----------------------------------------------------------------------------
// xsf channel interfaces
// Valid/ready channels for the command input and the result output.
// ----------------------------------------------------------------------------
interface xsf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] row_bits;
  logic       last_row;

  modport source (output valid, operation, pos_x, pos_y, row_bits, last_row,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_y, row_bits, last_row,
                  output ready);
endinterface

interface xsf_out_if;
  logic       valid;
  logic       ready;
  logic       collided;
  logic [7:0] pixels;

  modport source (output valid, collided, pixels, input ready);
  modport sink   (input valid, collided, pixels, output ready);
endinterface

FILE: sv/xsf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// xsf_cmd_fifo: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module xsf_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xsf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output xsf_pkg::cmd_t pop_data,
  output logic          empty
);
  import xsf_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       ent_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'(DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue underflow");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

FILE: sv/xsf_front.sv
// ----------------------------------------------------------------------------
// xsf_front: command intake
// Takes input transfers, tracks the sprite row offset, reduces line and
// start column to frame coordinates and pushes a command into the queue.
// ----------------------------------------------------------------------------
module xsf_front #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  xsf_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output xsf_pkg::cmd_t q_data
);
  import xsf_pkg::*;

  logic [7:0] off_r, off_nxt;
  logic [8:0] line_sum;

  // line modulo height by restoring subtraction of height * 2^k
  function automatic logic [LINE_W_MAX-1:0] line_mod(input logic [8:0] v);
    logic [11:0] r;
    r = {3'b000, v};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (12'(FRAME_HEIGHT) << k)) begin
        r = r - (12'(FRAME_HEIGHT) << k);
      end
    end
    return r[LINE_W_MAX-1:0];
  endfunction

  function automatic logic [COL_W_MAX-1:0] col_mod(input logic [7:0] v);
    logic [11:0] r;
    r = {4'b0000, v};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (12'(FRAME_WIDTH) << k)) begin
        r = r - (12'(FRAME_WIDTH) << k);
      end
    end
    return r[COL_W_MAX-1:0];
  endfunction

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    line_sum = {1'b0, in_ch.pos_y};
    if (in_ch.operation == OP_DRAW) begin
      line_sum = {1'b0, in_ch.pos_y} + {1'b0, off_r};
    end
    q_data.op   = in_ch.operation;
    q_data.line = line_mod(line_sum);
    q_data.col  = col_mod(in_ch.pos_x);
    q_data.bits = in_ch.row_bits;
    q_data.last = in_ch.last_row;
  end

  always_comb begin
    off_nxt = off_r;
    if (q_push && in_ch.operation == OP_DRAW) begin
      off_nxt = in_ch.last_row ? 8'd0 : off_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= 8'd0;
    end else begin
      off_r <= off_nxt;
    end
  end

  a_off_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_ch.operation == OP_DRAW && in_ch.last_row) |=> (off_r == 8'd0))
    else $error("row offset not cleared after last row");

  a_off_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_ch.operation == OP_DRAW && !in_ch.last_row)
      |=> (off_r == $past(off_r) + 8'd1))
    else $error("row offset did not advance");

  a_off_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && in_ch.operation == OP_DRAW) |=> $stable(off_r))
    else $error("row offset moved without a draw");

endmodule

FILE: sv/xsf_back.sv
// ----------------------------------------------------------------------------
// xsf_back: frame execution unit
// Frame memory with per-line valid bits, read-modify-write of one line per
// command, collision accumulator and the registered result stage.
// ----------------------------------------------------------------------------
module xsf_back #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  xsf_pkg::cmd_t q_data,
  output logic          q_pop,
  xsf_out_if.source     out_ch
);
  import xsf_pkg::*;

  localparam int LW = $clog2(FRAME_HEIGHT);
  localparam int CW = $clog2(FRAME_WIDTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                    st_r, st_nxt;
  cmd_t                    cmd_r;
  logic [FRAME_WIDTH-1:0]  mem [FRAME_HEIGHT];
  logic [FRAME_WIDTH-1:0]  rd_row_r;
  logic [FRAME_HEIGHT-1:0] row_vld_r, row_vld_nxt;
  logic                    rd_vld_r;
  logic                    acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_coll_r;
  logic [7:0]              out_pix_r;

  logic                    finish;
  logic                    mem_we;
  logic [LW-1:0]           cmd_line;
  logic [LW-1:0]           head_line;
  logic [FRAME_WIDTH-1:0]  old_row, new_row, mask;
  logic [CW-1:0]           col [ROW_PIXELS];
  logic [CW:0]             csum;
  logic [7:0]              pix_old, pix_new, res_pix;
  logic                    hit, res_coll;

  assign cmd_line  = cmd_r.line[LW-1:0];
  assign head_line = q_data.line[LW-1:0];
  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign finish    = (st_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign mem_we    = finish && (cmd_r.op == OP_DRAW);

  // eight wrapped columns starting at the command's start column
  always_comb begin
    for (int b = 0; b < ROW_PIXELS; b++) begin
      csum = {1'b0, cmd_r.col[CW-1:0]} + (CW+1)'(b);
      if (csum >= (CW+1)'(FRAME_WIDTH)) begin
        csum = csum - (CW+1)'(FRAME_WIDTH);
      end
      col[b] = csum[CW-1:0];
    end
  end

  always_comb begin
    old_row = rd_vld_r ? rd_row_r : '0;
    mask    = '0;
    for (int b = 0; b < ROW_PIXELS; b++) begin
      mask[col[b]] = cmd_r.bits[ROW_PIXELS-1-b];
    end
    new_row = old_row ^ mask;
    hit     = |(old_row & mask);
    for (int b = 0; b < ROW_PIXELS; b++) begin
      pix_old[ROW_PIXELS-1-b] = old_row[col[b]];
      pix_new[ROW_PIXELS-1-b] = new_row[col[b]];
    end
  end

  always_comb begin
    res_coll    = acc_r;
    res_pix     = 8'd0;
    acc_nxt     = acc_r;
    row_vld_nxt = row_vld_r;
    case (cmd_r.op)
      OP_DRAW: begin
        res_coll = acc_r | hit;
        res_pix  = pix_new;
        if (finish) begin
          acc_nxt = cmd_r.last ? 1'b0 : (acc_r | hit);
          row_vld_nxt[cmd_line] = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (finish) begin
          row_vld_nxt = '0;
        end
      end
      OP_READ: begin
        res_pix = pix_old;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_pop) st_nxt = ST_EXEC;
      ST_EXEC: if (finish) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_r       <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      acc_r       <= acc_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r    <= q_data;
      rd_vld_r <= row_vld_r[head_line];
    end
    if (finish) begin
      out_coll_r <= res_coll;
      out_pix_r  <= res_pix;
    end
  end

  // frame memory: registered read at pop, write at the end of a draw
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_row_r <= mem[head_line];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_line] <= new_row;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.collided = out_coll_r;
  assign out_ch.pixels   = out_pix_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE))
    else $error("queue popped while busy");

  a_draw_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> row_vld_r[$past(cmd_line)])
    else $error("drawn line not marked valid");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && cmd_r.op == OP_CLEAR) |=> (row_vld_r == '0))
    else $error("clear left valid lines");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before transfer");

endmodule

FILE: sv/xor_sprite_framebuffer.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer: one-bit XOR sprite framebuffer
// Draws 8-pixel sprite rows with collision detect, clears and reads the frame.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | operation, pos_x, pos_y, row_bits, last_row
//  out_ch  | out | valid / ready | collided, pixels
//
//  In the back end a command first does a registered read of the frame
//  line, then the XOR write and result load once the output slot is free.
//  Clear only resets per-line valid bits. A 2-entry queue sits between
//  intake and execution. Reset (synchronous, rst_n low) clears the frame
//  line valid bits, row offset and collision flag at once. A stalled output
//  holds the back end; intake keeps taking transfers until the queue is full.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  xsf_in_if.sink    in_ch,
  xsf_out_if.source out_ch
);
  import xsf_pkg::*;

  cmd_t push_data;
  cmd_t pop_data;
  logic q_push, q_pop, q_full, q_empty;

  xsf_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(push_data)
  );

  xsf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  xsf_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_data (pop_data),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

FILE: tb/sv/xsf_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xsf_result_checker: scoreboard for the XOR sprite framebuffer
// Watches both channels, keeps its own copy of the frame, sprite row counter
// and collision flag, predicts each result from accepted commands and
// compares returned results field by field in order.
// ----------------------------------------------------------------------------
module xsf_result_checker #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32
) (
  input  logic clk,
  input  logic rst_n,
  xsf_in_if    in_mon,
  xsf_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import xsf_pkg::*;

  typedef struct packed {
    logic       collided;
    logic [7:0] pixels;
  } pixel_result_t;

  logic [FRAME_WIDTH-1:0] frame_img [FRAME_HEIGHT];
  logic [7:0]             sprite_row;
  logic                   hit_accum;
  pixel_result_t          pending_results [$];

  function automatic logic [7:0] fetch_eight(int line, logic [7:0] x);
    logic [7:0] v;
    for (int b = 0; b < ROW_PIXELS; b++)
      v[ROW_PIXELS-1-b] = frame_img[line][(int'(x) + b) % FRAME_WIDTH];
    return v;
  endfunction

  task automatic predict_command(input logic [1:0] op, input logic [7:0] x,
                                 input logic [7:0] y, input logic [7:0] bits,
                                 input logic last, output pixel_result_t res);
    int   line;
    int   col;
    logic hit;
    res.collided = hit_accum;
    res.pixels   = '0;
    hit          = 1'b0;
    case (op)
      OP_DRAW: begin
        // sum is taken at full width, no 8-bit wrap before the modulo
        line = (int'(y) + int'(sprite_row)) % FRAME_HEIGHT;
        for (int b = 0; b < ROW_PIXELS; b++) begin
          col = (int'(x) + b) % FRAME_WIDTH;
          if (bits[ROW_PIXELS-1-b]) begin
            if (frame_img[line][col]) hit = 1'b1;
            frame_img[line][col] = ~frame_img[line][col];
          end
        end
        res.collided = hit_accum | hit;
        res.pixels   = fetch_eight(line, x);
        if (last) begin
          hit_accum  = 1'b0;
          sprite_row = '0;
        end else begin
          hit_accum  = res.collided;
          sprite_row = sprite_row + 8'd1;
        end
      end
      OP_CLEAR: begin
        for (int l = 0; l < FRAME_HEIGHT; l++) frame_img[l] = '0;
      end
      OP_READ: begin
        res.pixels = fetch_eight(int'(y) % FRAME_HEIGHT, x);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (!rst_n) begin
      for (int l = 0; l < FRAME_HEIGHT; l++) frame_img[l] = '0;
      sprite_row = '0;
      hit_accum  = 1'b0;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_command(in_mon.operation, in_mon.pos_x, in_mon.pos_y, in_mon.row_bits,
                        in_mon.last_row, exp_res);
        pending_results.push_back(exp_res);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing outstanding: collided %0d pixels 8'h%02h",
                 out_mon.collided, out_mon.pixels);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_mon.collided !== exp_res.collided) begin
            $error("collided mismatch: expected %0d, actual %0d",
                   exp_res.collided, out_mon.collided);
            fail_count++;
          end
          if (out_mon.pixels !== exp_res.pixels) begin
            $error("pixels mismatch: expected 8'h%02h, actual 8'h%02h",
                   exp_res.pixels, out_mon.pixels);
            fail_count++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: tb/sv/xor_sprite_framebuffer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_test: top of the sprite framebuffer testbench
// Drives directed corner commands, then random sprites, reads, clears and
// stray commands with random gaps on both channels and long output stalls.
// Checking is done by xsf_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_test;
  import xsf_pkg::*;

  localparam int         FRAME_W      = 64;
  localparam int         FRAME_H      = 32;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1550;
  localparam int         HOLD_CYCLES  = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  xsf_in_if  in_ch ();
  xsf_out_if out_ch ();

  int fail_count;
  int outstanding;
  int items_sent;
  int results_seen;
  int collisions_seen;
  int op_tally [4];
  bit no_idle;

  logic [7:0] prev_rows [$];
  logic [7:0] prev_x;
  logic [7:0] prev_y;

  xor_sprite_framebuffer #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xsf_result_checker #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) result_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                          input logic [7:0] bits, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.pos_x     = x;
    in_ch.pos_y     = y;
    in_ch.row_bits  = bits;
    in_ch.last_row  = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    op_tally[int'(op)]++;
  endtask

  // read, stray code or clear with random fields, dropped into a sprite
  task automatic send_noise();
    int   r;
    logic [1:0] op;
    r  = $urandom_range(9);
    op = (r < 6) ? OP_READ : (r < 9) ? OP_UNUSED : OP_CLEAR;
    send_cmd(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic draw_sprite(input int rows, input bit redraw);
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] bits;
    int         n;
    bit         again;
    bit         open_end;
    again    = redraw && (prev_rows.size() > 0);
    open_end = !again && ($urandom_range(99) < 5);
    if (again) begin
      x = prev_x;
      y = prev_y;
      n = prev_rows.size();
    end else begin
      x = 8'($urandom_range(255));
      y = 8'($urandom_range(255));
      n = rows;
      prev_rows.delete();
      prev_x = x;
      prev_y = y;
    end
    for (int r = 0; r < n; r++) begin
      if ($urandom_range(99) < 4) send_noise();
      if (again) begin
        bits = prev_rows[r];
      end else begin
        bits = 8'($urandom_range(255));
        prev_rows.push_back(bits);
      end
      send_cmd(OP_DRAW, x, y, bits, (r == n - 1) && !open_end);
    end
  endtask

  initial begin : stimulus
    int random_start;
    int r;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_DRAW;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    in_ch.row_bits  = '0;
    in_ch.last_row  = 1'b0;
    no_idle         = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    send_cmd(OP_READ,   8'd0,   8'd0,   8'h00, 1'b0);
    send_cmd(OP_DRAW,   8'd0,   8'd0,   8'hFF, 1'b1);
    send_cmd(OP_DRAW,   8'd0,   8'd0,   8'hFF, 1'b1);  // erases all: collision
    send_cmd(OP_DRAW,   8'd255, 8'd255, 8'h80, 1'b0);  // last column, last line
    send_cmd(OP_DRAW,   8'd60,  8'd255, 8'h01, 1'b0);  // y + offset past 255
    send_cmd(OP_DRAW,   8'd62,  8'd31,  8'hAA, 1'b1);
    send_cmd(OP_READ,   8'd255, 8'd255, 8'h00, 1'b0);
    send_cmd(OP_READ,   8'd60,  8'd0,   8'hFF, 1'b1);
    send_cmd(OP_READ,   8'd62,  8'd225, 8'h00, 1'b0);
    send_cmd(OP_DRAW,   8'd20,  8'd10,  8'h18, 1'b0);
    send_cmd(OP_DRAW,   8'd20,  8'd9,   8'h18, 1'b0);  // same line: collision
    send_cmd(OP_UNUSED, 8'd255, 8'd255, 8'hFF, 1'b1);  // mid-sprite, no effect
    send_cmd(OP_READ,   8'd20,  8'd10,  8'h00, 1'b0);  // no offset on read
    send_cmd(OP_CLEAR,  8'd20,  8'd10,  8'hFF, 1'b1);  // offset and flag kept
    send_cmd(OP_DRAW,   8'd20,  8'd8,   8'h00, 1'b1);  // flag still held
    send_cmd(OP_DRAW,   8'd20,  8'd10,  8'h3C, 1'b1);
    send_cmd(OP_READ,   8'd20,  8'd10,  8'h00, 1'b0);
    send_cmd(OP_DRAW,   8'd128, 8'd64,  8'hFF, 1'b0);
    send_cmd(OP_DRAW,   8'd128, 8'd64,  8'hFF, 1'b1);
    send_cmd(OP_CLEAR,  8'd0,   8'd0,   8'h00, 1'b0);
    send_cmd(OP_READ,   8'd0,   8'd0,   8'h00, 1'b0);
    send_cmd(OP_UNUSED, 8'd0,   8'd0,   8'h00, 1'b0);

    // random part; one sprite long enough to wrap the row counter
    random_start = items_sent;
    draw_sprite(270, 1'b0);
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 3) no_idle = !no_idle;
      r = $urandom_range(99);
      if (r < 55)      draw_sprite($urandom_range(15, 1), 1'b0);
      else if (r < 70) draw_sprite(0, 1'b1);
      else if (r < 88) send_cmd(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 91) send_cmd(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 1'($urandom_range(1)));
      else             send_noise();
    end
    in_ch.valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d commands: %0d draw rows, %0d clears, %0d reads, %0d stray codes",
             items_sent, op_tally[OP_DRAW], op_tally[OP_CLEAR], op_tally[OP_READ],
             op_tally[OP_UNUSED]);
    $display("Checked %0d results, %0d of them with the collision flag set",
             results_seen, collisions_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      // long hold-offs so the intake queue fills and input stalls
      if (holds_done < 2 && results_seen >= 300 + holds_done * 800) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (out_ch.collided) collisions_seen++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
